FILE: hdl/char_stream_tokenizer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character stream tokeniser.
// ----------------------------------------------------------------------------
`ifndef CHAR_STREAM_TOKENIZER_CORE_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CST_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CST_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Types, token kinds, character codes and helper functions of the tokeniser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

	// Scanner modes.
	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_DEC     = 4'd1,
		M_ZERO    = 4'd2,
		M_HEXPFX  = 4'd3,
		M_HEX     = 4'd4,
		M_IDENT   = 4'd5,
		M_OPEQ    = 4'd6,
		M_COMMENT = 4'd7
	} mode_t;

	// Token kinds.
	localparam logic [4:0] KIND_INT     = 5'd0;
	localparam logic [4:0] KIND_IDENT   = 5'd1;
	localparam logic [4:0] KIND_PLUS    = 5'd2;
	localparam logic [4:0] KIND_MINUS   = 5'd3;
	localparam logic [4:0] KIND_STAR    = 5'd4;
	localparam logic [4:0] KIND_SLASH   = 5'd5;
	localparam logic [4:0] KIND_PERCENT = 5'd6;
	localparam logic [4:0] KIND_ASSIGN  = 5'd7;
	localparam logic [4:0] KIND_LPAREN  = 5'd8;
	localparam logic [4:0] KIND_RPAREN  = 5'd9;
	localparam logic [4:0] KIND_COMMA   = 5'd10;
	localparam logic [4:0] KIND_EQ      = 5'd11;
	localparam logic [4:0] KIND_LT      = 5'd12;
	localparam logic [4:0] KIND_LE      = 5'd13;
	localparam logic [4:0] KIND_GT      = 5'd14;
	localparam logic [4:0] KIND_GE      = 5'd15;
	localparam logic [4:0] KIND_NE      = 5'd16;
	localparam logic [4:0] KIND_KW0     = 5'd17;
	localparam logic [4:0] KIND_END     = 5'd29;
	localparam logic [4:0] KIND_ERROR   = 5'd30;

	// Character codes.
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SP      = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_X       = 8'h78;

	localparam int PACKED_CHARS = 8;
	localparam int NUM_KEYWORDS = 12;

	// Keyword text, first character in the low byte.
	localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
		64'h0000_0000_0074_6573,  // set
		64'h0000_0074_6E69_7270,  // print
		64'h0000_0065_6C69_6877,  // while
		64'h0000_0000_0000_6F64,  // do
		64'h0000_0000_0064_6E65,  // end
		64'h0000_0000_0064_6E61,  // and
		64'h0000_0000_0000_726F,  // or
		64'h0000_0000_0000_6669,  // if
		64'h0000_0000_6E65_6874,  // then
		64'h0000_0000_6573_6C65,  // else
		64'h0000_0066_6964_6E65,  // endif
		64'h006D_6172_676F_7270   // program
	};
	localparam logic [7:0] KW_LEN [NUM_KEYWORDS] = '{
		8'd3, 8'd5, 8'd5, 8'd2, 8'd3, 8'd3, 8'd2, 8'd2, 8'd4, 8'd4, 8'd5, 8'd7
	};

	typedef struct packed {
		logic [4:0]  kind;
		logic [63:0] value;
		logic        ovf;
		logic [7:0]  len;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} tok_t;

	function automatic tok_t make_tok(input logic [4:0] kind, input logic [63:0] value,
			input logic ovf, input logic [7:0] len, input logic [15:0] line,
			input logic [15:0] col);
		tok_t t;
		t.kind  = kind;
		t.value = value;
		t.ovf   = ovf;
		t.len   = len;
		t.line  = line;
		t.col   = col;
		t.last  = 1'b0;
		return t;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
	endfunction

	// Returns {valid, nibble}.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (is_digit(c))
			r = {1'b1, c[3:0]};
		else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46)))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	// Kind of a single-character operator; KIND_INT when c is none.
	function automatic logic [4:0] single_op_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			CH_PLUS:    k = KIND_PLUS;
			CH_MINUS:   k = KIND_MINUS;
			CH_STAR:    k = KIND_STAR;
			CH_SLASH:   k = KIND_SLASH;
			CH_PERCENT: k = KIND_PERCENT;
			CH_LPAREN:  k = KIND_LPAREN;
			CH_RPAREN:  k = KIND_RPAREN;
			CH_COMMA:   k = KIND_COMMA;
			default:    k = KIND_INT;
		endcase
		return k;
	endfunction

	// An identifier longer than the packed text can never match, as no
	// keyword is that long.
	function automatic logic [4:0] keyword_kind(input logic [63:0] text,
			input logic [7:0] len);
		logic [4:0] k;
		k = KIND_IDENT;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			if ((len == KW_LEN[i]) && (text == KW_TEXT[i]))
				k = KIND_KW0 + 5'(i);
		end
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/char_stream_tokenizer_core.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer_core
// Streaming lexical analyser taking one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
// The char channel (char_valid/char_ready) carries one character, or an
// end-of-input mark, per transfer. The token channel (token_valid/token_ready)
// carries one token per transfer; last marks the final token caused by a
// given character. A character yields zero, one or two tokens.
// A character's tokens are registered into the output queue at its transfer.
// Throughput: one character per cycle while char_ready is high. The scanner
// state is registered at each transfer and its tokens go into a four-entry
// output queue; char_ready is high while the queue holds two entries or
// fewer, so a stalled receiver backs the input up once three tokens are
// waiting.
// Reset clears the scanner to idle at line 1, column 0, and empties the
// queue. End of input flushes any pending token, emits an end token and
// returns to idle, keeping line and column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_stream_tokenizer_core
	import cst_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_input,
	output logic             token_valid,
	input  wire logic        token_ready,
	output logic [4:0]       token_kind,
	output logic [63:0]      token_value,
	output logic             value_overflow,
	output logic [7:0]       text_length,
	output logic [15:0]      line_number,
	output logic [15:0]      column_number,
	output logic             last
);

	// Scanner state.
	mode_t       mode_q, mode_d;
	logic [63:0] acc_q, acc_d;
	logic [7:0]  len_q, len_d;
	logic        ovf_q, ovf_d;
	logic [15:0] line_q, line_d;
	logic [15:0] col_q, col_d;
	logic [15:0] tsc_q, tsc_d;

	// Output queue.
	tok_t        fifo_q [4];
	logic [1:0]  wr_q;
	logic [1:0]  rd_q;
	logic [2:0]  cnt_q;

	logic        accept;
	logic        pop;
	logic [1:0]  n_tok;
	logic [1:0]  n_push;
	tok_t        head;
	tok_t        w0, w1;

	logic        flush_v;
	tok_t        flush_tok;
	logic        tok_a_v, tok_b_v;
	tok_t        tok_a, tok_b;
	logic        do_flush, do_idle;

	logic        c_digit, c_alpha;
	logic [7:0]  c_lower;
	logic [4:0]  c_hex;
	logic [4:0]  c_op;
	logic [67:0] dec_prod;
	logic [15:0] col_inc, line_inc;
	logic [7:0]  len_inc;

	assign c_digit  = is_digit(char_code);
	assign c_alpha  = is_alpha(char_code);
	assign c_lower  = to_lower(char_code);
	assign c_hex    = hex_nibble(char_code);
	assign c_op     = single_op_kind(char_code);
	assign dec_prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, char_code[3:0]};
	assign col_inc  = (col_q == 16'hFFFF) ? col_q : col_q + 16'd1;
	assign line_inc = (line_q == 16'hFFFF) ? line_q : line_q + 16'd1;
	assign len_inc  = (len_q == 8'hFF) ? len_q : len_q + 8'd1;

	// Token left pending by the current mode.
	always_comb begin
		flush_v   = 1'b1;
		flush_tok = make_tok(KIND_INT, acc_q, ovf_q, len_q, line_q, tsc_q);
		case (mode_q)
			M_DEC, M_ZERO, M_HEX: begin
			end
			M_HEXPFX: flush_tok = make_tok(KIND_ERROR, 64'(CH_X), 1'b0, 8'd2, line_q, tsc_q);
			M_IDENT: flush_tok.kind = keyword_kind(acc_q, len_q);
			M_OPEQ: begin
				if (acc_q == 64'(CH_EQ))
					flush_tok = make_tok(KIND_ASSIGN, 64'd0, 1'b0, 8'd1, line_q, tsc_q);
				else if (acc_q == 64'(CH_LT))
					flush_tok = make_tok(KIND_LT, 64'd0, 1'b0, 8'd1, line_q, tsc_q);
				else if (acc_q == 64'(CH_GT))
					flush_tok = make_tok(KIND_GT, 64'd0, 1'b0, 8'd1, line_q, tsc_q);
				else
					flush_tok = make_tok(KIND_ERROR, 64'(CH_BANG), 1'b0, 8'd1, line_q, tsc_q);
			end
			default: flush_v = 1'b0;
		endcase
	end

	// Next state and tokens for the offered character.
	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		len_d    = len_q;
		ovf_d    = ovf_q;
		line_d   = line_q;
		col_d    = col_q;
		tsc_d    = tsc_q;
		tok_a_v  = 1'b0;
		tok_a    = flush_tok;
		tok_b_v  = 1'b0;
		tok_b    = make_tok(KIND_END, 64'd0, 1'b0, 8'd0, line_q, col_q);
		do_flush = 1'b0;
		do_idle  = 1'b0;

		if (end_of_input) begin
			do_flush = 1'b1;
			tok_b_v  = 1'b1;
		end else begin
			case (mode_q)
				M_DEC: begin
					if (c_digit) begin
						if (dec_prod[67:64] != 4'd0) begin
							acc_d = '1;
							ovf_d = 1'b1;
						end else begin
							acc_d = dec_prod[63:0];
						end
						len_d = len_inc;
						col_d = col_inc;
					end else begin
						do_flush = 1'b1;
						do_idle  = 1'b1;
					end
				end
				M_ZERO: begin
					if (char_code == CH_X) begin
						mode_d = M_HEXPFX;
						len_d  = len_inc;
						col_d  = col_inc;
					end else begin
						do_flush = 1'b1;
						do_idle  = 1'b1;
					end
				end
				M_HEXPFX, M_HEX: begin
					if (c_hex[4]) begin
						if (acc_q[63:60] != 4'd0) begin
							acc_d = '1;
							ovf_d = 1'b1;
						end else begin
							acc_d = {acc_q[59:0], c_hex[3:0]};
						end
						mode_d = M_HEX;
						len_d  = len_inc;
						col_d  = col_inc;
					end else begin
						do_flush = 1'b1;
						do_idle  = 1'b1;
					end
				end
				M_IDENT: begin
					if (c_alpha || c_digit || (char_code == CH_UNDER)) begin
						if (len_q < 8'(PACKED_CHARS)) begin
							for (int i = 0; i < PACKED_CHARS; i++) begin
								if (len_q == 8'(i))
									acc_d[8*i +: 8] = c_lower;
							end
						end else begin
							ovf_d = 1'b1;
						end
						len_d = len_inc;
						col_d = col_inc;
					end else begin
						do_flush = 1'b1;
						do_idle  = 1'b1;
					end
				end
				M_OPEQ: begin
					if (char_code == CH_EQ) begin
						tok_a_v = 1'b1;
						tok_a   = make_tok(KIND_NE, 64'd0, 1'b0, 8'd2, line_q, tsc_q);
						if (acc_q == 64'(CH_EQ))
							tok_a.kind = KIND_EQ;
						else if (acc_q == 64'(CH_LT))
							tok_a.kind = KIND_LE;
						else if (acc_q == 64'(CH_GT))
							tok_a.kind = KIND_GE;
						mode_d = M_IDLE;
						acc_d  = 64'd0;
						len_d  = 8'd0;
						col_d  = col_inc;
					end else begin
						do_flush = 1'b1;
						do_idle  = 1'b1;
					end
				end
				M_COMMENT: begin
					if (char_code == CH_NL)
						do_idle = 1'b1;
					else
						col_d = col_inc;
				end
				default: do_idle = 1'b1;
			endcase
		end

		if (do_flush) begin
			tok_a_v = flush_v;
			tok_a   = flush_tok;
			mode_d  = M_IDLE;
			acc_d   = 64'd0;
			len_d   = 8'd0;
			ovf_d   = 1'b0;
		end

		// Scan the character afresh with no token pending.
		if (do_idle) begin
			mode_d = M_IDLE;
			if (char_code == CH_NL) begin
				line_d = line_inc;
				col_d  = 16'd0;
			end else begin
				col_d = col_inc;
				if (char_code == CH_HASH) begin
					mode_d = M_COMMENT;
				end else if (c_digit || c_alpha ||
						(char_code == CH_EQ) || (char_code == CH_LT) ||
						(char_code == CH_GT) || (char_code == CH_BANG)) begin
					len_d = 8'd1;
					ovf_d = 1'b0;
					tsc_d = col_q;
					if (char_code == CH_ZERO) begin
						mode_d = M_ZERO;
						acc_d  = 64'd0;
					end else if (c_digit) begin
						mode_d = M_DEC;
						acc_d  = {60'd0, char_code[3:0]};
					end else if (c_alpha) begin
						mode_d = M_IDENT;
						acc_d  = {56'd0, c_lower};
					end else begin
						mode_d = M_OPEQ;
						acc_d  = {56'd0, char_code};
					end
				end else if (c_op != KIND_INT) begin
					tok_b_v = 1'b1;
					tok_b   = make_tok(c_op, 64'd0, 1'b0, 8'd1, line_q, col_q);
				end else if (char_code != CH_SP) begin
					tok_b_v = 1'b1;
					tok_b   = make_tok(KIND_ERROR, {56'd0, char_code}, 1'b0, 8'd1,
						line_q, col_q);
				end
			end
		end
	end

	// Queue write ordering: the flushed or two-character token first.
	always_comb begin
		n_tok   = {1'b0, tok_a_v} + {1'b0, tok_b_v};
		w0      = tok_a_v ? tok_a : tok_b;
		w0.last = !(tok_a_v && tok_b_v);
		w1      = tok_b;
		w1.last = 1'b1;
	end

	assign char_ready  = (cnt_q <= 3'd2);
	assign accept      = char_valid && char_ready;
	assign n_push      = accept ? n_tok : 2'd0;
	assign token_valid = (cnt_q != 3'd0);
	assign pop         = token_valid && token_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q  <= 64'd0;
			len_q  <= 8'd0;
			ovf_q  <= 1'b0;
			line_q <= 16'd1;
			col_q  <= 16'd0;
			tsc_q  <= 16'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			len_q  <= len_d;
			ovf_q  <= ovf_d;
			line_q <= line_d;
			col_q  <= col_d;
			tsc_q  <= tsc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + n_push;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

	// Pushes only happen with at most two entries held, so neither write
	// slot can be the head that is on offer.
	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			fifo_q[wr_q] <= w0;
		if (n_push == 2'd2)
			fifo_q[wr_q + 2'd1] <= w1;
	end

	assign head           = fifo_q[rd_q];
	assign token_kind     = head.kind;
	assign token_value    = head.value;
	assign value_overflow = head.ovf;
	assign text_length    = head.len;
	assign line_number    = head.line;
	assign column_number  = head.col;
	assign last           = head.last;

endmodule

`default_nettype wire

FILE: hdl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks on the token channel of the tokeniser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "char_stream_tokenizer_core_defines.svh"

module cst_checker
	import cst_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        token_valid,
	input wire logic        token_ready,
	input wire logic [4:0]  token_kind,
	input wire logic [63:0] token_value,
	input wire logic        value_overflow,
	input wire logic [7:0]  text_length,
	input wire logic        last
);

	// A stalled token must hold its contents.
	`CST_ASSERT_NXT(a_token_hold, clk, arst_n, token_valid && !token_ready, token_valid && $stable(token_kind) && $stable(token_value) && $stable(last), "stalled token changed")

	// The queue is empty when reset is released.
	`CST_ASSERT_IMP(a_empty_after_reset, clk, arst_n, $rose(arst_n), !token_valid, "token offered straight after reset")

	// Both tokens of a character are queued together, so the second one is
	// already waiting when the first is taken.
	`CST_ASSERT_NXT(a_pair_together, clk, arst_n, token_valid && token_ready && !last, token_valid, "second token of a pair missing")

	// The end token closes its character and carries no text.
	`CST_ASSERT_IMP(a_end_token, clk, arst_n, token_valid && (token_kind == KIND_END), last && (token_value == 64'd0) && (text_length == 8'd0), "malformed end token")

	// Only literals and identifiers can report overflow.
	`CST_ASSERT_IMP(a_overflow_kind, clk, arst_n, token_valid && value_overflow, (token_kind == KIND_INT) || (token_kind == KIND_IDENT), "overflow on wrong token kind")

endmodule

bind char_stream_tokenizer_core cst_checker u_cst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.token_valid    (token_valid),
	.token_ready    (token_ready),
	.token_kind     (token_kind),
	.token_value    (token_value),
	.value_overflow (value_overflow),
	.text_length    (text_length),
	.last           (last)
);

`default_nettype wire
